FILE: rtl/cttf_pkg.sv
package cttf_pkg;

   typedef enum logic [2:0] {
      ST_OFF         = 3'd0,
      ST_READY       = 3'd1,
      ST_INVENTORY   = 3'd2,
      ST_SELECTED    = 3'd3,
      ST_DESELECTED  = 3'd4,
      ST_DEACTIVATED = 3'd5,
      ST_INVALID     = 3'd6
   } proto_state_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_REPLY  = 2'd1,
      KIND_IGNORE = 2'd2
   } reply_kind_type;

   localparam logic [7:0] OP_INITIATE   = 8'h06;
   localparam logic [3:0] OP_SLOT_MASK  = 4'h6;
   localparam logic [7:0] OP_SELECT     = 8'h0e;
   localparam logic [7:0] OP_READ       = 8'h08;
   localparam logic [7:0] OP_WRITE      = 8'h09;
   localparam logic [7:0] OP_UID        = 8'h0b;
   localparam logic [7:0] OP_RESET_INV  = 8'h0c;
   localparam logic [7:0] OP_COMPLETION = 8'h0f;

   localparam logic [7:0] LEN_SHORT = 8'd1;
   localparam logic [7:0] LEN_ARG   = 8'd2;
   localparam logic [7:0] LEN_WRITE = 8'd6;

   localparam logic [7:0] CHIP_ID_RESET = 8'h42;

   localparam int STORE_DEPTH = 19;
   localparam int IDX_W       = $clog2(STORE_DEPTH);

   localparam logic [7:0] ADDR_ALIAS_LO   = 8'h7e;
   localparam logic [7:0] ADDR_ALIAS_HI   = 8'h7f;
   localparam logic [7:0] ADDR_ALIAS_LAST = 8'hff;
   localparam logic [7:0] IDX_UID_LO      = 8'd16;
   localparam logic [7:0] IDX_UID_HI      = 8'd17;
   localparam logic [7:0] IDX_LAST        = 8'd18;
   localparam logic [7:0] SAVE_ADDR       = 8'h60;
   localparam logic [31:0] SAVE_ANSWER    = 32'hbebafeca;

   localparam logic [3:0] LEN_NONE  = 4'd0;
   localparam logic [3:0] LEN_ID    = 4'd1;
   localparam logic [3:0] LEN_BLOCK = 4'd4;
   localparam logic [3:0] LEN_UID   = 4'd8;

   localparam logic [31:0] FACTORY_IMAGE [STORE_DEPTH] = '{
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'hbbcc_ddee, 32'hd002_33aa, 32'hffff_ffff
   };

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic is_field_reset;
      logic is_initiate;
      logic is_select;
      logic is_slot;
      logic is_reset_inv;
      logic is_completion;
      logic is_uid;
      logic is_read;
      logic is_write;
      logic is_save;
      logic idx_valid;
   } cmd_flags_type;

   typedef struct packed {
      cmd_flags_type     flags;
      logic [7:0]        arg_byte;
      logic [IDX_W-1:0]  idx;
      logic [31:0]       write_word;
   } work_item_type;

endpackage

FILE: rtl/cttf_front.sv
module cttf_front
   import cttf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_action,
   input  logic [7:0]    req_frame_len,
   input  logic [7:0]    req_cmd_byte,
   input  logic [7:0]    req_arg_byte,
   input  logic [31:0]   req_write_word,
   output logic          item_valid,
   input  logic          item_ready,
   output work_item_type item
);

   logic          valid_ff;
   logic          valid_in;
   work_item_type item_ff;
   work_item_type item_in;
   logic [7:0]    mapped;
   logic          len_short;
   logic          len_arg;

   assign req_ready = !valid_ff || item_ready;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_comb begin
      case (req_arg_byte)
         ADDR_ALIAS_LO:   mapped = IDX_UID_LO;
         ADDR_ALIAS_HI:   mapped = IDX_UID_HI;
         ADDR_ALIAS_LAST: mapped = IDX_LAST;
         default:         mapped = req_arg_byte;
      endcase
   end

   assign len_short = (req_frame_len == LEN_SHORT);
   assign len_arg   = (req_frame_len == LEN_ARG);

   always_comb begin
      item_in.flags.is_field_reset = req_action;
      item_in.flags.is_initiate    = len_arg && (req_cmd_byte == OP_INITIATE);
      item_in.flags.is_select      = len_arg && (req_cmd_byte == OP_SELECT);
      item_in.flags.is_slot        = (req_frame_len != 8'd0)
                                     && (req_cmd_byte[3:0] == OP_SLOT_MASK);
      item_in.flags.is_reset_inv   = len_short && (req_cmd_byte == OP_RESET_INV);
      item_in.flags.is_completion  = len_short && (req_cmd_byte == OP_COMPLETION);
      item_in.flags.is_uid         = len_short && (req_cmd_byte == OP_UID);
      item_in.flags.is_read        = len_arg && (req_cmd_byte == OP_READ);
      item_in.flags.is_write       = (req_frame_len == LEN_WRITE)
                                     && (req_cmd_byte == OP_WRITE);
      item_in.flags.is_save        = (mapped == SAVE_ADDR);
      item_in.flags.idx_valid      = (mapped < 8'(STORE_DEPTH));
      item_in.arg_byte             = req_arg_byte;
      item_in.idx                  = mapped[IDX_W-1:0];
      item_in.write_word           = req_write_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/cttf_queue.sv
module cttf_queue
   import cttf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  work_item_type push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output work_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_item_type     entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/cttf_back.sv
module cttf_back
   import cttf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [7:0]    csr_write_data,
   input  logic          item_valid,
   output logic          item_ready,
   input  work_item_type item,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_reply_kind,
   output logic [3:0]    rsp_reply_len,
   output logic [63:0]   rsp_reply_bytes,
   output logic [2:0]    rsp_new_state,
   output logic          rsp_save_request
);

   proto_state_type state_ff;
   proto_state_type state_in;
   logic [7:0]      chip_id_ff;
   logic [31:0]     store_ff [STORE_DEPTH];
   logic            rsp_valid_ff;
   reply_kind_type  kind_ff;
   reply_kind_type  kind_in;
   logic [3:0]      len_ff;
   logic [3:0]      len_in;
   logic [63:0]     bytes_ff;
   logic [63:0]     bytes_in;
   proto_state_type new_state_ff;
   logic            save_ff;
   logic            save_in;
   logic            store_write;
   logic            advance;
   logic [31:0]     read_word;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign advance    = item_valid && item_ready;
   assign read_word  = store_ff[item.idx];

   always_comb begin
      state_in = state_ff;
      if (item.flags.is_field_reset) begin
         state_in = ST_OFF;
      end else begin
         case (state_ff)
            ST_OFF, ST_READY: begin
               state_in = item.flags.is_initiate ? ST_INVENTORY : ST_INVALID;
            end
            ST_INVENTORY, ST_DESELECTED: begin
               if (item.flags.is_select) begin
                  if (item.arg_byte == chip_id_ff) begin
                     state_in = ST_SELECTED;
                  end
               end else if (!((state_ff == ST_INVENTORY) && item.flags.is_slot)) begin
                  state_in = ST_OFF;
               end
            end
            ST_SELECTED: begin
               if (item.flags.is_reset_inv) begin
                  state_in = ST_INVENTORY;
               end else if (item.flags.is_completion) begin
                  state_in = ST_DEACTIVATED;
               end
            end
            default: begin
               state_in = ST_OFF;
            end
         endcase
      end
   end

   always_comb begin
      len_in      = LEN_NONE;
      bytes_in    = '0;
      save_in     = 1'b0;
      store_write = 1'b0;
      if (!item.flags.is_field_reset) begin
         case (state_ff)
            ST_OFF, ST_READY: begin
               if (item.flags.is_initiate) begin
                  len_in   = LEN_ID;
                  bytes_in = {56'd0, chip_id_ff};
               end
            end
            ST_INVENTORY, ST_DESELECTED: begin
               if (item.flags.is_select
                   || ((state_ff == ST_INVENTORY) && item.flags.is_slot)) begin
                  len_in   = LEN_ID;
                  bytes_in = {56'd0, chip_id_ff};
               end
            end
            ST_SELECTED: begin
               if (item.flags.is_uid) begin
                  len_in   = LEN_UID;
                  bytes_in = {store_ff[IDX_UID_HI[IDX_W-1:0]],
                              store_ff[IDX_UID_LO[IDX_W-1:0]]};
               end else if (item.flags.is_read && item.flags.idx_valid) begin
                  len_in   = LEN_BLOCK;
                  bytes_in = {32'd0, read_word};
               end else if (item.flags.is_write) begin
                  if (item.flags.idx_valid) begin
                     store_write = 1'b1;
                  end else if (item.flags.is_save) begin
                     save_in  = 1'b1;
                     len_in   = LEN_BLOCK;
                     bytes_in = {32'd0, SAVE_ANSWER};
                  end
               end
            end
            default: begin
               len_in = LEN_NONE;
            end
         endcase
      end
      if (item.flags.is_field_reset) begin
         kind_in = KIND_NONE;
      end else if (len_in != LEN_NONE) begin
         kind_in = KIND_REPLY;
      end else if (state_in != ST_INVALID) begin
         kind_in = KIND_IGNORE;
      end else begin
         kind_in = KIND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_OFF;
         chip_id_ff   <= CHIP_ID_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= FACTORY_IMAGE[i];
         end
      end else begin
         if (csr_write_enable) begin
            chip_id_ff <= csr_write_data;
         end
         if (advance) begin
            state_ff <= state_in;
            if (store_write) begin
               store_ff[item.idx] <= item.write_word;
            end
         end
         if (item_ready) begin
            rsp_valid_ff <= item_valid;
         end
      end
      if (advance) begin
         kind_ff      <= kind_in;
         len_ff       <= len_in;
         bytes_ff     <= bytes_in;
         new_state_ff <= state_in;
         save_ff      <= save_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reply_kind   = kind_ff;
   assign rsp_reply_len    = len_ff;
   assign rsp_reply_bytes  = bytes_ff;
   assign rsp_new_state    = new_state_ff;
   assign rsp_save_request = save_ff;

endmodule

FILE: rtl/contactless_tag_target_fsm.sv
// A result passes the front register, the queue entry and the back's rsp registers before it is on the rsp side.
// Throughput: one frame per cycle while rsp_ready and a full queue do not stall the flow.
// A two-entry queue between decode and execute lets either side stall on its own.
// Reset is synchronous and active high: protocol state off, chip ID 0x42, store
// loaded with the factory image, all pipeline and queue entries empty.
module contactless_tag_target_fsm
   import cttf_pkg::*;
#(
   parameter int QUEUE_ENTRIES = QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [7:0]    csr_write_data,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_action,
   input  logic [7:0]    req_frame_len,
   input  logic [7:0]    req_cmd_byte,
   input  logic [7:0]    req_arg_byte,
   input  logic [31:0]   req_write_word,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_reply_kind,
   output logic [3:0]    rsp_reply_len,
   output logic [63:0]   rsp_reply_bytes,
   output logic [2:0]    rsp_new_state,
   output logic          rsp_save_request
);

   logic          front_valid;
   logic          front_ready;
   work_item_type front_item;
   logic          back_valid;
   logic          back_ready;
   work_item_type back_item;

   cttf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_frame_len  (req_frame_len),
      .req_cmd_byte   (req_cmd_byte),
      .req_arg_byte   (req_arg_byte),
      .req_write_word (req_write_word),
      .item_valid     (front_valid),
      .item_ready     (front_ready),
      .item           (front_item)
   );

   cttf_queue #(
      .DEPTH (QUEUE_ENTRIES)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   cttf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (back_valid),
      .item_ready       (back_ready),
      .item             (back_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reply_kind   (rsp_reply_kind),
      .rsp_reply_len    (rsp_reply_len),
      .rsp_reply_bytes  (rsp_reply_bytes),
      .rsp_new_state    (rsp_new_state),
      .rsp_save_request (rsp_save_request)
   );

endmodule
